// File: hw/rtl/hmp_pkg.sv
`timescale 1ns / 1ps

package hmp_pkg;

  localparam int BODY_MAX = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int TEMPO_LEN = 7;

  localparam logic [1:0] CFG_LOOP_TRACK = 2'd0;
  localparam logic [1:0] CFG_INSERT_TEMPO = 2'd1;
  localparam logic [1:0] CFG_TEMPO_US = 2'd2;

  localparam logic [23:0] TEMPO_RESET = 24'd500000;

  localparam logic [7:0] META_STATUS = 8'hff;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] TEMPO_DATA_LEN = 8'h03;
  localparam logic [7:0] SYSEX_STATUS = 8'hf0;

  localparam logic [7:0] CTRL_REMAP_LO = 8'd102;
  localparam logic [7:0] CTRL_REMAP_HI = 8'd119;
  localparam logic [6:0] CTRL_LOOP_START = 7'd110;
  localparam logic [6:0] CTRL_LOOP_END = 7'd111;
  localparam logic [7:0] CTRL_LOOP_START_OUT = 8'd118;
  localparam logic [7:0] CTRL_LOOP_END_OUT = 8'd119;
  localparam logic [7:0] CTRL_NEUTRAL = 8'd102;
  localparam logic [7:0] CTRL_FULL_VALUE = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       delta_overflow;
  } out_t;

  typedef struct packed {
    logic                      tempo;
    logic                      ovf;
    logic [3:0]                n;
    logic [BODY_MAX-1:0][7:0]  body;
  } job_t;

  // data length of a channel status, by status bits 6:4; has_len low means none
  function automatic logic [1:0] cmd_len(input logic [2:0] idx, output logic has_len);
    logic [1:0] len;
    has_len = 1'b1;
    case (idx)
      3'd4, 3'd5: len = 2'd1;
      3'd7: begin
        len = 2'd0;
        has_len = 1'b0;
      end
      default: len = 2'd2;
    endcase
    return len;
  endfunction

  // data length of a system common status, by the low nibble
  function automatic logic [1:0] sys_len(input logic [3:0] idx);
    logic [1:0] len;
    case (idx)
      4'd2: len = 2'd2;
      4'd3: len = 2'd1;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/hmp_track_to_midi_converter.sv
`timescale 1ns / 1ps
// channel   direction  transfer when          payload
// in        input      in_valid & in_ready    in_data (data_byte, track_start)
// out       output     out_valid & out_ready  out_data (out_byte, last_of_run, delta_overflow)
// cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// one input byte is taken per cycle while the four-entry job queue has room
// the output stage presents the result bytes of the queue head in order; a byte that
// causes n results holds the queue head until all n are presented, giving runs of up to 7 + n bytes
// the first result is registered in the job queue and then in the output stage
// synchronous reset clears parse state, queue, output stage and config flags, and sets tempo_us to 500000
// output stalls back up through the queue and then drop in_ready

module hmp_track_to_midi_converter #(
  parameter int MAX_DELTA_DIGITS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hmp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hmp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_wdata
);

  logic          loop_track;
  logic          insert_tempo;
  logic [23:0]   tempo_us;
  logic          q_full;
  logic          push;
  logic          pop;
  logic          head_valid;
  hmp_pkg::job_t push_job;
  hmp_pkg::job_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_track <= 1'b0;
      insert_tempo <= 1'b0;
      tempo_us <= hmp_pkg::TEMPO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hmp_pkg::CFG_LOOP_TRACK: loop_track <= cfg_wdata[0];
        hmp_pkg::CFG_INSERT_TEMPO: insert_tempo <= cfg_wdata[0];
        hmp_pkg::CFG_TEMPO_US: tempo_us <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hmp_front #(
    .MAX_DIGITS(MAX_DELTA_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .loop_track   (loop_track),
    .insert_tempo (insert_tempo),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  hmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hmp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .tempo_us   (tempo_us),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: hw/rtl/hmp_front.sv
`timescale 1ns / 1ps

module hmp_front #(
  parameter int MAX_DIGITS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hmp_pkg::in_t  in_data,
  input  logic          loop_track,
  input  logic          insert_tempo,
  input  logic          q_full,
  output logic          push,
  output hmp_pkg::job_t job
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_EVENT,
    PH_SYSEX,
    PH_META_TYPE,
    PH_META_LEN,
    PH_DATA,
    PH_CTRL,
    PH_CTRL_VAL
  } phase_t;

  phase_t          phase, phase_next;
  logic [6:0]      digits [MAX_DIGITS];
  logic [6:0]      digits_next [MAX_DIGITS];
  logic [CW-1:0]   dcount, dcount_next;
  logic            ovf, ovf_next;
  logic [7:0]      rs, rs_next;
  logic [7:0]      brem, brem_next;
  logic [6:0]      held, held_next;
  logic            accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign push = accept && ((job.n != 4'd0) || job.tempo);

  always_comb begin
    logic [7:0]    b;
    logic          ts;
    logic          do_delta;
    logic          has_len;
    logic [1:0]    len;
    logic [CW-1:0] dc_e;
    logic [CW-1:0] cnt;
    logic [CW-1:0] sel;
    logic          ovf_new;
    b = in_data.data_byte;
    ts = in_data.track_start;
    do_delta = 1'b0;
    has_len = 1'b0;
    len = 2'd0;
    cnt = '0;
    sel = '0;
    ovf_new = 1'b0;
    dc_e = ts ? '0 : dcount;
    phase_next = ts ? PH_DELTA : phase;
    dcount_next = dc_e;
    ovf_next = ts ? 1'b0 : ovf;
    rs_next = ts ? 8'd0 : rs;
    brem_next = ts ? 8'd0 : brem;
    held_next = ts ? 7'd0 : held;
    digits_next = digits;
    job = '0;
    job.tempo = ts && insert_tempo;

    case (phase_next)
      PH_EVENT: begin
        if (b[7]) begin
          job.n = 4'd1;
          job.body[0] = b;
          rs_next = b;
          if (b[7:4] == 4'hf) begin
            if (b == hmp_pkg::SYSEX_STATUS) begin
              phase_next = PH_SYSEX;
            end else if (b == hmp_pkg::META_STATUS) begin
              phase_next = PH_META_TYPE;
            end else begin
              len = hmp_pkg::sys_len(b[3:0]);
              if (len != 2'd0) begin
                brem_next = {6'd0, len};
                phase_next = PH_DATA;
              end else begin
                phase_next = PH_DELTA;
              end
            end
          end else if (b[7:4] == 4'hb) begin
            phase_next = PH_CTRL;
          end else begin
            len = hmp_pkg::cmd_len(b[6:4], has_len);
            brem_next = {6'd0, len};
            phase_next = PH_DATA;
          end
        end else begin
          len = hmp_pkg::cmd_len(rs_next[6:4], has_len);
          if (has_len) begin
            job.n = 4'd1;
            job.body[0] = b;
            if (len == 2'd2) begin
              brem_next = 8'd1;
              phase_next = PH_DATA;
            end else begin
              phase_next = PH_DELTA;
            end
          end else begin
            phase_next = PH_DELTA;
            do_delta = 1'b1;
          end
        end
      end
      PH_SYSEX: begin
        job.n = 4'd1;
        job.body[0] = b;
        if (b[7]) begin
          phase_next = PH_DELTA;
        end
      end
      PH_META_TYPE: begin
        job.n = 4'd1;
        job.body[0] = b;
        phase_next = PH_META_LEN;
      end
      PH_META_LEN: begin
        job.n = 4'd1;
        job.body[0] = b;
        if (b != 8'd0) begin
          brem_next = b;
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_DELTA;
        end
      end
      PH_DATA: begin
        job.n = 4'd1;
        job.body[0] = b;
        brem_next = brem_next - 8'd1;
        if (brem_next == 8'd0) begin
          phase_next = PH_DELTA;
        end
      end
      PH_CTRL: begin
        if (b >= hmp_pkg::CTRL_REMAP_LO && b <= hmp_pkg::CTRL_REMAP_HI) begin
          held_next = b[6:0];
          phase_next = PH_CTRL_VAL;
        end else begin
          job.n = 4'd1;
          job.body[0] = b;
          brem_next = 8'd1;
          phase_next = PH_DATA;
        end
      end
      PH_CTRL_VAL: begin
        job.n = 4'd2;
        if (loop_track && held_next == hmp_pkg::CTRL_LOOP_START) begin
          job.body[0] = hmp_pkg::CTRL_LOOP_START_OUT;
          job.body[1] = {1'b0, b[6:0]};
        end else if (loop_track && held_next == hmp_pkg::CTRL_LOOP_END) begin
          job.body[0] = hmp_pkg::CTRL_LOOP_END_OUT;
          job.body[1] = hmp_pkg::CTRL_FULL_VALUE;
        end else begin
          job.body[0] = hmp_pkg::CTRL_NEUTRAL;
          job.body[1] = 8'd0;
        end
        phase_next = PH_DELTA;
      end
      default: begin
        do_delta = 1'b1;
      end
    endcase

    if (do_delta) begin
      ovf_new = ovf_next;
      if (dc_e < CW'(MAX_DIGITS)) begin
        digits_next[dc_e[IW-1:0]] = b[6:0];
        cnt = dc_e + CW'(1);
      end else begin
        ovf_new = 1'b1;
        cnt = dc_e;
      end
      if (b[7]) begin
        // most significant digit first, continuation bit on all but the last
        for (int k = 0; k < MAX_DIGITS; k++) begin
          sel = cnt - CW'(1) - CW'(k);
          if (CW'(k) < cnt) begin
            job.body[k] = {(CW'(k + 1) < cnt), digits_next[sel[IW-1:0]]};
          end
        end
        job.n = 4'(cnt);
        job.ovf = ovf_new;
        dcount_next = '0;
        ovf_next = 1'b0;
        phase_next = PH_EVENT;
      end else begin
        dcount_next = cnt;
        ovf_next = ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DELTA;
      dcount <= '0;
      ovf <= 1'b0;
      rs <= 8'd0;
      brem <= 8'd0;
      held <= 7'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= 7'd0;
      end
    end else if (accept) begin
      phase <= phase_next;
      dcount <= dcount_next;
      ovf <= ovf_next;
      rs <= rs_next;
      brem <= brem_next;
      held <= held_next;
      digits <= digits_next;
    end
  end

endmodule

// File: hw/rtl/hmp_queue.sv
`timescale 1ns / 1ps

module hmp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hmp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output hmp_pkg::job_t head
);

  localparam int PW = $clog2(hmp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(hmp_pkg::QUEUE_DEPTH + 1);

  hmp_pkg::job_t entries [hmp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == CW'(hmp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/hmp_back.sv
`timescale 1ns / 1ps

module hmp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  hmp_pkg::job_t head,
  input  logic [23:0]   tempo_us,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output hmp_pkg::out_t out_data
);

  logic [3:0]    idx;
  logic [3:0]    total;
  logic [3:0]    body_idx;
  logic          in_tempo;
  logic          is_last;
  logic          advance;
  hmp_pkg::out_t item;

  assign total = (head.tempo ? 4'(hmp_pkg::TEMPO_LEN) : 4'd0) + head.n;
  assign in_tempo = head.tempo && (idx < 4'(hmp_pkg::TEMPO_LEN));
  assign body_idx = idx - (head.tempo ? 4'(hmp_pkg::TEMPO_LEN) : 4'd0);
  assign is_last = (idx == total - 4'd1);
  assign advance = head_valid && (!out_valid || out_ready);
  assign pop = advance && is_last;

  always_comb begin
    item.last_of_run = is_last;
    item.delta_overflow = 1'b0;
    item.out_byte = 8'd0;
    if (in_tempo) begin
      case (idx)
        4'd0: item.out_byte = 8'h00;
        4'd1: item.out_byte = hmp_pkg::META_STATUS;
        4'd2: item.out_byte = hmp_pkg::META_TEMPO;
        4'd3: item.out_byte = hmp_pkg::TEMPO_DATA_LEN;
        4'd4: item.out_byte = tempo_us[23:16];
        4'd5: item.out_byte = tempo_us[15:8];
        default: item.out_byte = tempo_us[7:0];
      endcase
    end else begin
      item.out_byte = head.body[body_idx[2:0]];
      item.delta_overflow = head.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx <= is_last ? 4'd0 : idx + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/hmp_checker.sv
`timescale 1ns / 1ps

module hmp_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input hmp_pkg::out_t out_data
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // nothing shown right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // flagged delta bytes before the last carry the continuation bit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.delta_overflow && !out_data.last_of_run
      |-> out_data.out_byte[7])
    else $error("overflowed delta byte missing continuation bit");

  // flagged final delta byte has no continuation bit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.delta_overflow && out_data.last_of_run
      |-> !out_data.out_byte[7])
    else $error("final delta byte has continuation bit");

endmodule

bind hmp_track_to_midi_converter hmp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
